// File: rtl/core/ultrasonic_ranging_controller_macros.svh
// Assertion macros for the ultrasonic ranging controller checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef ULTRASONIC_RANGING_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGING_CONTROLLER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define URC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define URC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/urc_pkg.sv
// Shared constants for the ultrasonic ranging controller.
// No dependencies; imported by the top level and its checker.
package urc_pkg;

  localparam int unsigned SensorCountDefault = 4;

  // Sequencer phases
  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhTrigLow  = 3'd1;
  localparam logic [2:0] PhTrigHigh = 3'd2;
  localparam logic [2:0] PhSettle   = 3'd3;
  localparam logic [2:0] PhWaitRise = 3'd4;
  localparam logic [2:0] PhMeasure  = 3'd5;
  localparam logic [2:0] PhGap      = 3'd6;

  // Commands
  localparam logic [1:0] CmdTick       = 2'd0;
  localparam logic [1:0] CmdMeasureOne = 2'd1;
  localparam logic [1:0] CmdMeasureAll = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgEchoTimeout  = 2'd0;
  localparam logic [1:0] CfgMaxDistance  = 2'd1;
  localparam logic [1:0] CfgInvalidCode  = 2'd2;

  // Phase lengths in ticks
  localparam logic [16:0] LowTicks    = 17'd2;
  localparam logic [16:0] HighTicks   = 17'd10;
  localparam logic [16:0] SettleTicks = 17'd50;
  localparam logic [16:0] GapTicks    = 17'd10000;

  // Distance = ticks * SoundMul / SoundDiv, tracked as quotient and remainder
  localparam logic [14:0] SoundMul = 15'd343;
  localparam logic [14:0] SoundDiv = 15'd20000;

  // Reset values
  localparam logic [15:0] EchoTimeoutReset = 16'd30000;
  localparam logic [10:0] MaxDistanceReset = 11'd400;
  localparam logic [15:0] InvalidCodeReset = 16'hFFFF;

endpackage

// File: rtl/core/ultrasonic_ranging_controller.sv
// Ultrasonic echo ranging controller: one microsecond tick per input transaction.
// Depends on urc_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tick each: a command, the
//   sensor to measure, the echo line levels and a query index. Output channel
//   (out_valid_o/out_ready_i) returns exactly one result transaction per tick:
//   trigger drive, busy flag, single-measurement result, measure-all summary
//   and the stored distance of the queried sensor.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes echo timeout, max
//   distance and invalid distance code; it is always ready. Write only while
//   no tick is outstanding.
// Latency and throughput:
//   A tick is processed in the cycle it is accepted and its result appears on
//   the output register the next cycle. One tick per cycle is sustained: the
//   input stays ready while the output register is empty or being drained.
//   The distance quotient is kept as a running quotient/remainder that grows
//   by 343/20000 every measuring tick, so no multiplier or divider is needed.
// Reset: sequencer idle, counters cleared, stored distances read 65535,
//   registers at their defaults, output register empty.
// Stall: when out_ready_i is low and a result is held, in_ready_o drops and
//   the sequencer freezes until the result is taken.
module ultrasonic_ranging_controller
  import urc_pkg::*;
#(
  parameter int unsigned SENSOR_COUNT = SensorCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  sensor_id_i,
  input  logic [3:0]  echo_levels_i,
  input  logic [1:0]  query_id_i,
  // tick result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  trigger_lines_o,
  output logic        busy_res_o,
  output logic        result_valid_o,
  output logic [1:0]  result_sensor_o,
  output logic [15:0] distance_cm_o,
  output logic        result_status_o,
  output logic        all_done_o,
  output logic        all_failed_o,
  output logic [15:0] queried_distance_o
);

  localparam int unsigned ActW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  // Configuration registers
  logic [15:0] echo_timeout_q;
  logic [10:0] max_dist_q;
  logic [15:0] invalid_code_q;

  // Sequencer state
  logic [2:0]      phase_q, phase_d;
  logic [16:0]     timer_q, timer_d;
  logic [ActW-1:0] active_q, active_d;
  logic            sweep_q, sweep_d;
  logic            sweep_err_q, sweep_err_d;
  logic [10:0]     quot_q, quot_d;
  logic [14:0]     rem_q, rem_d;
  logic [15:0]     store_q [SENSOR_COUNT];
  logic [15:0]     store_d [SENSOR_COUNT];

  // Output register
  logic        out_valid_q;
  logic [3:0]  trig_q, trig_d;
  logic        busy_q, busy_d;
  logic        rvalid_q, rvalid_d;
  logic [1:0]  rsensor_q, rsensor_d;
  logic [15:0] dist_q, dist_d;
  logic        rstatus_q, rstatus_d;
  logic        adone_q, adone_d;
  logic        afail_q, afail_d;
  logic [15:0] qdist_q, qdist_d;

  logic        in_fire;
  logic        echo_hi;
  logic [16:0] timer_inc;
  logic [14:0] rem_sum;
  logic        rem_wrap;
  logic [10:0] quot_next;
  logic [14:0] rem_next;
  logic [10:0] dist_clamped;
  logic        done;
  logic        failed;
  logic        store_wr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_timeout_q <= EchoTimeoutReset;
      max_dist_q     <= MaxDistanceReset;
      invalid_code_q <= InvalidCodeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEchoTimeout: echo_timeout_q <= cfg_data_i;
        CfgMaxDistance: max_dist_q     <= cfg_data_i[10:0];
        CfgInvalidCode: invalid_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running distance: remainder advances by 343 per measuring tick, wraps at 20000.
  assign rem_sum      = rem_q + SoundMul;
  assign rem_wrap     = rem_sum >= SoundDiv;
  assign quot_next    = quot_q + 11'(rem_wrap);
  assign rem_next     = rem_wrap ? (rem_sum - SoundDiv) : rem_sum;
  assign dist_clamped = (quot_next > max_dist_q) ? max_dist_q : quot_next;

  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    active_d    = active_q;
    sweep_d     = sweep_q;
    sweep_err_d = sweep_err_q;
    quot_d      = '0;
    rem_d       = '0;
    trig_d      = '0;
    rvalid_d    = 1'b0;
    rsensor_d   = '0;
    dist_d      = '0;
    rstatus_d   = 1'b0;
    adone_d     = 1'b0;
    afail_d     = 1'b0;
    done        = 1'b0;
    failed      = 1'b0;
    store_wr    = 1'b0;
    echo_hi     = 1'b0;

    // Start a sequence from idle; anything else in idle is a plain tick.
    if (phase_q == PhIdle) begin
      if (command_i == CmdMeasureOne && 32'(sensor_id_i) < SENSOR_COUNT) begin
        active_d    = ActW'(sensor_id_i);
        sweep_d     = 1'b0;
        sweep_err_d = 1'b0;
        phase_d     = PhTrigLow;
        timer_d     = '0;
      end else if (command_i == CmdMeasureAll) begin
        active_d    = '0;
        sweep_d     = 1'b1;
        sweep_err_d = 1'b0;
        phase_d     = PhTrigLow;
        timer_d     = '0;
      end
    end
    busy_d = phase_d != PhIdle;

    // Sensors beyond the four echo lines see echo low.
    for (int i = 0; i < 4; i++) begin
      if (32'(active_d) == i && echo_levels_i[i]) begin
        echo_hi = 1'b1;
      end
    end

    timer_inc = timer_d + 17'd1;

    case (phase_d)
      PhTrigLow: begin
        timer_d = timer_inc;
        if (timer_inc >= LowTicks) begin
          phase_d = PhTrigHigh;
          timer_d = '0;
        end
      end
      PhTrigHigh: begin
        for (int i = 0; i < 4; i++) begin
          trig_d[i] = 32'(active_d) == i;
        end
        timer_d = timer_inc;
        if (timer_inc >= HighTicks) begin
          phase_d = PhSettle;
          timer_d = '0;
        end
      end
      PhSettle: begin
        timer_d = timer_inc;
        if (timer_inc >= SettleTicks) begin
          phase_d = PhWaitRise;
          timer_d = '0;
        end
      end
      PhWaitRise: begin
        if (echo_hi) begin
          phase_d = PhMeasure;
          timer_d = '0;
        end else begin
          timer_d = timer_inc;
          if (timer_inc > {1'b0, echo_timeout_q}) begin
            done   = 1'b1;
            failed = 1'b1;
          end
        end
      end
      PhMeasure: begin
        timer_d = timer_inc;
        quot_d  = quot_next;
        rem_d   = rem_next;
        if (!echo_hi) begin
          done     = 1'b1;
          dist_d   = 16'(dist_clamped);
          store_wr = 1'b1;
        end else if (timer_inc > {1'b0, echo_timeout_q}) begin
          done   = 1'b1;
          failed = 1'b1;
        end
      end
      PhGap: begin
        timer_d = timer_inc;
        if (timer_inc >= GapTicks) begin
          timer_d = '0;
          if (32'(active_d) + 32'd1 >= SENSOR_COUNT) begin
            phase_d = PhIdle;
            adone_d = 1'b1;
            afail_d = sweep_err_d;
            sweep_d = 1'b0;
          end else begin
            active_d = active_d + ActW'(1);
            phase_d  = PhTrigLow;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
        timer_d = '0;
      end
    endcase

    // Close out a single-sensor measurement.
    if (done) begin
      rvalid_d  = 1'b1;
      rsensor_d = 2'(active_d);
      if (failed) begin
        dist_d    = invalid_code_q;
        rstatus_d = 1'b1;
      end
      timer_d = '0;
      if (sweep_d) begin
        if (failed) begin
          sweep_err_d = 1'b1;
        end
        phase_d = PhGap;
      end else begin
        phase_d = PhIdle;
      end
    end

    // Stored distances, updated before the query reads them.
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      store_d[i] = store_q[i];
    end
    if (store_wr) begin
      store_d[active_d] = 16'(dist_clamped);
    end
    if (32'(query_id_i) < SENSOR_COUNT) begin
      qdist_d = store_d[ActW'(query_id_i)];
    end else begin
      qdist_d = invalid_code_q;
    end
  end

  // Advance the sequencer only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      timer_q     <= '0;
      active_q    <= '0;
      sweep_q     <= 1'b0;
      sweep_err_q <= 1'b0;
      quot_q      <= '0;
      rem_q       <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        store_q[i] <= InvalidCodeReset;
      end
    end else if (in_fire) begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      active_q    <= active_d;
      sweep_q     <= sweep_d;
      sweep_err_q <= sweep_err_d;
      quot_q      <= quot_d;
      rem_q       <= rem_d;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        store_q[i] <= store_d[i];
      end
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      trig_q    <= trig_d;
      busy_q    <= busy_d;
      rvalid_q  <= rvalid_d;
      rsensor_q <= rsensor_d;
      dist_q    <= dist_d;
      rstatus_q <= rstatus_d;
      adone_q   <= adone_d;
      afail_q   <= afail_d;
      qdist_q   <= qdist_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trigger_lines_o    = trig_q;
  assign busy_res_o         = busy_q;
  assign result_valid_o     = rvalid_q;
  assign result_sensor_o    = rsensor_q;
  assign distance_cm_o      = dist_q;
  assign result_status_o    = rstatus_q;
  assign all_done_o         = adone_q;
  assign all_failed_o       = afail_q;
  assign queried_distance_o = qdist_q;

endmodule

// File: rtl/core/urc_checker.sv
// Port-level checker for the ultrasonic ranging controller, bound to the top level.
// Depends on urc_pkg and ultrasonic_ranging_controller_macros.svh.
`include "ultrasonic_ranging_controller_macros.svh"

module urc_checker
  import urc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  command_i,
  input logic [1:0]  sensor_id_i,
  input logic [3:0]  echo_levels_i,
  input logic [1:0]  query_id_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  trigger_lines_o,
  input logic        busy_res_o,
  input logic        result_valid_o,
  input logic [1:0]  result_sensor_o,
  input logic [15:0] distance_cm_o,
  input logic        result_status_o,
  input logic        all_done_o,
  input logic        all_failed_o,
  input logic [15:0] queried_distance_o
);

  // Hold a stalled result transaction.
  `URC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_cm_o) && $stable(queried_distance_o), "stalled result changed")

  // An empty output register never blocks input.
  `URC_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  // Quiet result fields when no measurement completes.
  `URC_ASSERT(a_result_quiet, out_valid_o && !result_valid_o |-> distance_cm_o == 16'd0 && result_status_o == 1'b0 && result_sensor_o == 2'd0, "result fields not cleared")

  // Summary flags and trigger drive only inside a running sequence.
  `URC_ASSERT(a_seq_flags, out_valid_o |-> (!all_failed_o || all_done_o) && $onehot0(trigger_lines_o) && (trigger_lines_o == 4'd0 || busy_res_o) && (!result_valid_o || busy_res_o), "sequence flags inconsistent")

endmodule

bind ultrasonic_ranging_controller urc_checker u_urc_checker (.*);
